@@ hw/rtl/websocket_frame_deframer_unit_assert.svh @@
// Assertion macros shared by the WebSocket deframer RTL.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/wsfd_pkg.sv @@
// Shared types and codes for the WebSocket frame deframer.
// No dependencies; imported by the parser and the top level.
`timescale 1ns / 1ps

package wsfd_pkg;

   localparam int ByteWidth = 8;
   localparam int KindWidth = 2;
   localparam int OpcodeWidth = 4;

   // Result kinds.
   localparam logic [KindWidth-1:0] KIND_HEADER  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KindWidth-1:0] KIND_EMPTY   = 2'd2;

   typedef struct packed {
      logic [KindWidth-1:0]   kind;
      logic [ByteWidth-1:0]   payload_byte;
      logic [OpcodeWidth-1:0] frame_opcode;
      logic                   frame_fin;
      logic                   last_in_frame;
   } result_type;

endpackage

@@ hw/rtl/wsfd_parser.sv @@
// Frame parse state and the per-byte decode of the WebSocket deframer.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps

module wsfd_parser
   import wsfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [ByteWidth-1:0] data_byte,
   output result_type           result
);

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_MASK    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES = 4'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [3:0]  left_ff, left_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;

   logic [KindWidth-1:0] kind;
   logic [ByteWidth-1:0] pbyte;
   logic [ByteWidth-1:0] key_byte;
   logic                 len_done;
   logic                 hdr_done;
   logic                 zero_len;

   always_comb begin
      unique case (idx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      left_in   = left_ff;
      remain_in = remain_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      kind      = KIND_HEADER;
      pbyte     = '0;
      len_done  = 1'b0;
      hdr_done  = 1'b0;

      unique case (phase_ff)
         PH_SECOND: begin
            masked_in = data_byte[7];
            key_in    = '0;
            if (data_byte[6:0] == LEN_EXT16) begin
               remain_in = '0;
               left_in   = EXT16_BYTES;
               phase_in  = PH_EXTLEN;
            end else if (data_byte[6:0] == LEN_EXT64) begin
               remain_in = '0;
               left_in   = EXT64_BYTES;
               phase_in  = PH_EXTLEN;
            end else begin
               remain_in = {57'd0, data_byte[6:0]};
               len_done  = 1'b1;
            end
         end
         PH_EXTLEN: begin
            remain_in = {remain_ff[55:0], data_byte};
            left_in   = left_ff - 4'd1;
            len_done  = (left_in == 4'd0);
         end
         PH_MASK: begin
            key_in   = {key_ff[23:0], data_byte};
            left_in  = left_ff - 4'd1;
            hdr_done = (left_in == 4'd0);
         end
         PH_PAYLOAD: begin
            pbyte     = masked_ff ? (data_byte ^ key_byte) : data_byte;
            kind      = KIND_PAYLOAD;
            idx_in    = idx_ff + 2'd1;
            remain_in = remain_ff - 64'd1;
            if (remain_in == 64'd0) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            // Unused phase codes also take the byte as a first header byte.
            fin_in    = data_byte[7];
            opcode_in = data_byte[3:0];
            phase_in  = PH_SECOND;
         end
      endcase

      // Once the length is known, a masked frame still has its key to read.
      if (len_done) begin
         if (masked_in) begin
            left_in  = KEY_BYTES;
            phase_in = PH_MASK;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         idx_in = '0;
         if (remain_in == 64'd0) begin
            phase_in = PH_FIRST;
            kind     = KIND_EMPTY;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   assign zero_len = (remain_in == 64'd0);

   assign result.kind          = kind;
   assign result.payload_byte  = pbyte;
   assign result.frame_opcode  = opcode_in;
   assign result.frame_fin     = fin_in;
   assign result.last_in_frame = (kind == KIND_EMPTY) || ((kind == KIND_PAYLOAD) && zero_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         masked_ff <= 1'b0;
         left_ff   <= '0;
         remain_ff <= '0;
         key_ff    <= '0;
         idx_ff    <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         left_ff   <= left_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

@@ hw/rtl/websocket_frame_deframer_unit.sv @@
// WebSocket receive-side frame deframer: one stream byte in, one result out per byte.
// The deframer sustains one byte per clock while the result side accepts: a request
// is captured in an input register, decoded combinationally against the frame state
// (including the 64-bit payload countdown and the 4-byte unmasking key), and the
// result is held in an output register. A new request is taken every cycle while
// the result side keeps accepting; when the result side stalls, one request
// waits in the input register and further requests are stalled. Depends on
// wsfd_pkg, wsfd_parser and websocket_frame_deframer_unit_assert.svh.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_unit_assert.svh"

module websocket_frame_deframer_unit
   import wsfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ByteWidth-1:0]   req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KindWidth-1:0]   rsp_kind,
   output logic [ByteWidth-1:0]   rsp_payload_byte,
   output logic [OpcodeWidth-1:0] rsp_frame_opcode,
   output logic                   rsp_frame_fin,
   output logic                   rsp_last_in_frame
);

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   result_type           step_result;
   logic                 advance;
   logic                 req_take;

   // A request moves to the result register when that register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_frame_opcode  = out_ff.frame_opcode;
   assign rsp_frame_fin     = out_ff.frame_fin;
   assign rsp_last_in_frame = out_ff.last_in_frame;

   `WSFD_ASSERT_SAME(a_backpressure, clock, reset, in_valid_ff && out_valid_ff && rsp_stall, req_stall, "input register must hold while the result is stalled")
   `WSFD_ASSERT_SAME(a_payload_zero, clock, reset, rsp_valid && (rsp_kind != KIND_PAYLOAD), rsp_payload_byte == '0, "non-payload result carries a payload byte")
   `WSFD_ASSERT_SAME(a_empty_last, clock, reset, rsp_valid && (rsp_kind == KIND_EMPTY), rsp_last_in_frame, "empty frame result must end the frame")
   `WSFD_ASSERT_NEXT(a_no_drop, clock, reset, in_valid_ff && !advance, in_valid_ff, "pending request lost")

endmodule
